// ===== rtl/core/lbfv_pkg.sv =====
`default_nettype none
package lbfv_pkg;

  localparam int DATA_W = 32;
  localparam int VEL_W  = 16;
  localparam int COEF_W = 34;
  localparam int DIV_W  = 63;
  localparam int DVS_W  = 32;

  localparam int GAMMA_LIMIT = 1024;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] G_CLAMP = 32'(GAMMA_LIMIT * 65536);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // register map, word index
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_VEL_X = 2'd0;
  localparam reg_idx_t REG_VEL_Y = 2'd1;
  localparam reg_idx_t REG_VEL_Z = 2'd2;

  // c00, cross terms c0i, space block (11,22,33,12,13,23)
  typedef struct packed {
    coef_t       c00;
    coef_t [2:0] ce;
    coef_t [5:0] cs;
    logic        clamped;
    logic        ready;
  } coef_set_t;

  typedef struct packed {
    logic             start;
    logic             clr;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/lbfv_div.sv =====
`default_nettype none
module lbfv_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lbfv_pkg::div_req_t   req,
  output lbfv_pkg::div_rsp_t   rsp
);
  import lbfv_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DIV_W-1:0] quo_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh      = {rem_r, quo_r[DIV_W-1]};
    diff    = sh - {1'b0, dvs_r};
    ge      = (sh >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/lbfv_coef.sv =====
`default_nettype none
module lbfv_coef (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_wr,
  input  lbfv_pkg::vel_t       vel_x,
  input  lbfv_pkg::vel_t       vel_y,
  input  lbfv_pkg::vel_t       vel_z,
  output lbfv_pkg::coef_set_t  coef,
  output lbfv_pkg::div_req_t   div_req,
  input  lbfv_pkg::div_rsp_t   div_rsp
);
  import lbfv_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SQ    = 10'b0000000010,
    ST_GAM   = 10'b0000000100,
    ST_GDIV  = 10'b0000001000,
    ST_SQRT  = 10'b0000010000,
    ST_CROSS = 10'b0000100000,
    ST_VV    = 10'b0001000000,
    ST_NUM   = 10'b0010000000,
    ST_SPLIT = 10'b0100000000,
    ST_CDIV  = 10'b1000000000
  } state_t;

  // row/column of each space-block term
  localparam logic [1:0] PI [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [1:0] PJ [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  state_t              state_r;
  logic [1:0]          idx_r;
  logic [2:0]          pk_r;
  logic [31:0]         b2_r;
  logic [31:0]         g_r;
  logic                clamp_r;
  logic [63:0]         rad_r;
  logic [33:0]         srem_r;
  logic [31:0]         root_r;
  logic [4:0]          scnt_r;
  logic signed [31:0]  vv_r;
  logic signed [63:0]  num_r;
  logic                neg_r;
  coef_t               c00_r;
  coef_t               ce_r [3];
  coef_t               cs_r [6];

  vel_t                v [3];
  logic signed [31:0]  sq;
  logic signed [31:0]  gm1;
  logic signed [49:0]  gv;
  logic signed [49:0]  gsh;
  logic signed [31:0]  vv_nxt;
  logic signed [63:0]  num_nxt;
  logic signed [63:0]  mag;
  logic [35:0]         r4;
  logic [35:0]         trial;
  logic [35:0]         rdiff;
  logic                sge;
  logic                big;
  logic                diag;
  coef_t               qt;
  coef_t               cs_nxt;

  always_comb begin
    v[0]    = vel_x;
    v[1]    = vel_y;
    v[2]    = vel_z;
    sq      = 32'(v[idx_r]) * 32'(v[idx_r]);
    gm1     = $signed(g_r - ONE_Q16);
    gv      = -($signed({18'b0, g_r}) * 50'(v[idx_r]));
    gsh     = gv >>> 15;
    vv_nxt  = 32'(v[PI[pk_r]]) * 32'(v[PJ[pk_r]]);
    num_nxt = gm1 * vv_r;
    mag     = num_r[63] ? -num_r : num_r;
    r4      = {srem_r, rad_r[63:62]};
    trial   = {2'b00, root_r, 2'b01};
    rdiff   = r4 - trial;
    sge     = (r4 >= trial);
    big     = (b2_r >= 32'h4000_0000);
    diag    = (pk_r < 3'd3);
    qt      = neg_r ? -$signed({1'b0, div_rsp.quo[COEF_W-2:0]})
                    : $signed({1'b0, div_rsp.quo[COEF_W-2:0]});
    cs_nxt  = qt + (diag ? coef_t'(ONE_Q16) : coef_t'(0));
  end

  always_comb begin
    div_req.clr      = cfg_wr;
    div_req.start    = ((state_r == ST_GAM) && !big) ||
                       ((state_r == ST_SPLIT) && (b2_r != 32'd0));
    div_req.dividend = (state_r == ST_GAM) ? {1'b1, 62'b0} : mag[DIV_W-1:0];
    div_req.divisor  = (state_r == ST_GAM) ? (32'h4000_0000 - b2_r) : b2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      state_r <= ST_SQ;
      idx_r   <= '0;
      b2_r    <= '0;
      clamp_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: ;
        ST_SQ: begin
          b2_r <= b2_r + 32'(sq);
          if (idx_r == 2'd2) begin
            state_r <= ST_GAM;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        ST_GAM: begin
          idx_r <= '0;
          if (big) begin
            g_r     <= G_CLAMP;
            clamp_r <= 1'b1;
            state_r <= ST_CROSS;
          end else begin
            clamp_r <= 1'b0;
            state_r <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          if (div_rsp.done) begin
            rad_r   <= {1'b0, div_rsp.quo};
            srem_r  <= '0;
            root_r  <= '0;
            scnt_r  <= '0;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          // two radicand bits per cycle
          srem_r <= sge ? rdiff[33:0] : r4[33:0];
          root_r <= {root_r[30:0], sge};
          rad_r  <= {rad_r[61:0], 2'b00};
          scnt_r <= scnt_r + 5'd1;
          if (scnt_r == 5'd31) begin
            g_r     <= {root_r[30:0], sge};
            state_r <= ST_CROSS;
          end
        end
        ST_CROSS: begin
          c00_r        <= coef_t'(g_r);
          ce_r[idx_r]  <= gsh[COEF_W-1:0];
          pk_r         <= '0;
          if (idx_r == 2'd2) begin
            state_r <= ST_VV;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        ST_VV: begin
          vv_r    <= vv_nxt;
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          num_r   <= num_nxt;
          state_r <= ST_SPLIT;
        end
        ST_SPLIT: begin
          neg_r <= num_r[63];
          if (b2_r == 32'd0) begin
            // zero velocity: identity block
            cs_r[pk_r] <= diag ? coef_t'(ONE_Q16) : coef_t'(0);
            pk_r       <= pk_r + 3'd1;
            state_r    <= (pk_r == 3'd5) ? ST_IDLE : ST_VV;
          end else begin
            state_r <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (div_rsp.done) begin
            cs_r[pk_r] <= cs_nxt;
            pk_r       <= pk_r + 3'd1;
            state_r    <= (pk_r == 3'd5) ? ST_IDLE : ST_VV;
          end
        end
        default: state_r <= ST_SQ;
      endcase
    end
  end

  always_comb begin
    coef.c00     = c00_r;
    coef.clamped = clamp_r;
    coef.ready   = (state_r == ST_IDLE);
    for (int i = 0; i < 3; i++) begin
      coef.ce[i] = ce_r[i];
    end
    for (int k = 0; k < 6; k++) begin
      coef.cs[k] = cs_r[k];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lbfv_mac.sv =====
`default_nettype none
module lbfv_mac (
  input  wire                  clk,
  input  wire                  rst_n,
  input  lbfv_pkg::coef_set_t  coef,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  lbfv_pkg::data_t      in_t,
  input  lbfv_pkg::data_t      in_x,
  input  lbfv_pkg::data_t      in_y,
  input  lbfv_pkg::data_t      in_z,
  output logic                 out_valid,
  input  wire                  out_ready,
  output lbfv_pkg::data_t      out_t,
  output lbfv_pkg::data_t      out_x,
  output lbfv_pkg::data_t      out_y,
  output lbfv_pkg::data_t      out_z,
  output logic                 out_clamped
);
  import lbfv_pkg::*;

  coef_t              cm [4][4];
  data_t              xv [4];

  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic signed [49:0] ph_r [4][4];
  logic signed [50:0] pl_r [4][4];
  logic signed [51:0] a_r [4];
  logic signed [52:0] b_r [4];
  data_t              o_r [4];

  logic signed [51:0] a_nxt [4];
  logic signed [52:0] b_nxt [4];
  logic signed [52:0] r [4];
  data_t              o_nxt [4];
  logic               rdy1;
  logic               rdy2;
  logic               rdy3;

  always_comb begin
    cm[0][0] = coef.c00;
    for (int k = 0; k < 3; k++) begin
      cm[0][k+1] = coef.ce[k];
      cm[k+1][0] = coef.ce[k];
      cm[k+1][k+1] = coef.cs[k];
    end
    cm[1][2] = coef.cs[3];
    cm[2][1] = coef.cs[3];
    cm[1][3] = coef.cs[4];
    cm[3][1] = coef.cs[4];
    cm[2][3] = coef.cs[5];
    cm[3][2] = coef.cs[5];
    xv[0] = in_t;
    xv[1] = in_x;
    xv[2] = in_y;
    xv[3] = in_z;
  end

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1 && coef.ready;

  // words are split into a signed high and unsigned low half;
  // floor(sum/2^16) = sum(c*hi) + floor(sum(c*lo)/2^16)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_nxt[i] = '0;
      b_nxt[i] = '0;
      for (int j = 0; j < 4; j++) begin
        a_nxt[i] = a_nxt[i] + 52'(ph_r[i][j]);
        b_nxt[i] = b_nxt[i] + 53'(pl_r[i][j]);
      end
      r[i] = 53'(a_r[i]) + (b_r[i] >>> 16);
      if (r[i] > 53'sd2147483647) begin
        o_nxt[i] = 32'sh7fff_ffff;
      end else if (r[i] < -53'sd2147483648) begin
        o_nxt[i] = 32'sh8000_0000;
      end else begin
        o_nxt[i] = r[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid && coef.ready;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          ph_r[i][j] <= cm[i][j] * $signed(xv[j][31:16]);
          pl_r[i][j] <= cm[i][j] * $signed({1'b0, xv[j][15:0]});
        end
      end
    end
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 4; i++) begin
        a_r[i] <= a_nxt[i];
        b_r[i] <= b_nxt[i];
      end
    end
    if (rdy3 && v2_r) begin
      for (int i = 0; i < 4; i++) begin
        o_r[i] <= o_nxt[i];
      end
    end
  end

  assign out_valid   = v3_r;
  assign out_t       = o_r[0];
  assign out_x       = o_r[1];
  assign out_y       = o_r[2];
  assign out_z       = o_r[3];
  assign out_clamped = coef.clamped;

endmodule
`default_nettype wire

// ===== rtl/core/lorentz_boost_four_vector.sv =====
`default_nettype none
// Boosts a stream of four-vectors (t, x, y, z; signed Q16.16) by the velocity
// held in vel_x/vel_y/vel_z (signed Q1.15, byte addresses 0x0, 0x4, 0x8). One
// word is taken per clock while in_ready is high. Each word passes a multiply,
// a row sum and a round/saturate register stage, and its result is held in the
// last of these until out_ready takes it. The boost matrix is not built per
// word: after reset and after every register write a coefficient engine
// (beta^2, a 63-step shared divider for 2^62/(1-beta^2), a 32-step square
// root for gamma, then one division per space term) rebuilds it, during
// which in_ready is low. Speeds of 1 or more use gamma = 1024 and set
// out_gamma_clamped.
module lorentz_boost_four_vector (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [3:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_ready,
  input  lbfv_pkg::data_t    in_t_in,
  input  lbfv_pkg::data_t    in_x_in,
  input  lbfv_pkg::data_t    in_y_in,
  input  lbfv_pkg::data_t    in_z_in,
  output logic               out_valid,
  input  wire                out_ready,
  output lbfv_pkg::data_t    out_t_out,
  output lbfv_pkg::data_t    out_x_out,
  output lbfv_pkg::data_t    out_y_out,
  output lbfv_pkg::data_t    out_z_out,
  output logic               out_gamma_clamped
);
  import lbfv_pkg::*;

  vel_t      vel_x_r;
  vel_t      vel_y_r;
  vel_t      vel_z_r;
  logic      wr;
  reg_idx_t  ridx;
  coef_set_t coef;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_x_r <= '0;
      vel_y_r <= '0;
      vel_z_r <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_VEL_X: vel_x_r <= pwdata[15:0];
        REG_VEL_Y: vel_y_r <= pwdata[15:0];
        REG_VEL_Z: vel_z_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_VEL_X: prdata = {16'b0, vel_x_r};
      REG_VEL_Y: prdata = {16'b0, vel_y_r};
      REG_VEL_Z: prdata = {16'b0, vel_z_r};
      default:   prdata = '0;
    endcase
  end

  lbfv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lbfv_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (wr),
    .vel_x   (vel_x_r),
    .vel_y   (vel_y_r),
    .vel_z   (vel_z_r),
    .coef    (coef),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  lbfv_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .coef        (coef),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_t        (in_t_in),
    .in_x        (in_x_in),
    .in_y        (in_y_in),
    .in_z        (in_z_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_t       (out_t_out),
    .out_x       (out_x_out),
    .out_y       (out_y_out),
    .out_z       (out_z_out),
    .out_clamped (out_gamma_clamped)
  );

endmodule
`default_nettype wire
